FILE: design/iso_date_parse_day_number_unit_macros.svh
// Assertion macros for the ISO date parser with day-number output.
// Included by modules that check their own logic; needs no package.
`ifndef ISO_DATE_PARSE_DAY_NUMBER_UNIT_MACROS_SVH
`define ISO_DATE_PARSE_DAY_NUMBER_UNIT_MACROS_SVH

// Same-cycle implication.
`define ISO_DP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ISO_DP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/iso_dp_pkg.sv
// Package for the ISO date parser: widths, codes, the parsed-date record and
// calendar tables. No dependencies.
`timescale 1ns / 1ps

package iso_dp_pkg;

	localparam int YEAR_BITS = 16;

	localparam int CH_W      = 8;
	localparam int STATUS_W  = 3;
	localparam int YEAR_W    = 16;
	localparam int MONTH_W   = 4;
	localparam int DAY_W     = 5;
	localparam int DAY_NUM_W = 25;

	localparam logic [YEAR_BITS-1:0] ACC_MAX = {YEAR_BITS{1'b1}};

	// x / 25 for x < 2**(YEAR_BITS-2) as (x * DIV_MUL) >> DIV_SHIFT
	localparam int DIV_SHIFT = YEAR_BITS + 3;
	localparam longint unsigned DIV_MUL = ((64'd1 << DIV_SHIFT) + 64'd24) / 64'd25;
	localparam int REC_W  = $clog2(DIV_MUL + 1);
	localparam int PROD_W = YEAR_BITS - 2 + REC_W;
	localparam int Q_W    = PROD_W - DIV_SHIFT;

	// 365*y plus leap days and day of year
	localparam int DN_W = YEAR_BITS + 9;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CH_W-1:0] CH_HYPHEN = 8'h2D;
	localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE   = 8'h39;

	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_MALFORMED = 3'd1,
		ST_YEAR_BAD  = 3'd2,
		ST_MONTH_BAD = 3'd3,
		ST_DAY_BAD   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FLD_YEAR  = 2'd0,
		FLD_MONTH = 2'd1,
		FLD_DAY   = 2'd2
	} field_t;

	typedef struct packed {
		logic                 bad_syntax;
		logic                 year_sat;
		logic [YEAR_BITS-1:0] year;
		logic [MONTH_W-1:0]   month;
		logic                 day_sat;
		logic [YEAR_BITS-1:0] day;
	} date_rec_t;

	function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] db;
		case (m)
			4'd1:    db = 9'd0;
			4'd2:    db = 9'd31;
			4'd3:    db = 9'd59;
			4'd4:    db = 9'd90;
			4'd5:    db = 9'd120;
			4'd6:    db = 9'd151;
			4'd7:    db = 9'd181;
			4'd8:    db = 9'd212;
			4'd9:    db = 9'd243;
			4'd10:   db = 9'd273;
			4'd11:   db = 9'd304;
			4'd12:   db = 9'd334;
			default: db = 9'd0;
		endcase
		return db;
	endfunction

endpackage

FILE: design/iso_dp_char_if.sv
// Byte channel of the ISO date parser: valid/ready plus one string byte.
// Depends on iso_dp_pkg.
`timescale 1ns / 1ps

interface iso_dp_char_if import iso_dp_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

FILE: design/iso_dp_result_if.sv
// Result channel of the ISO date parser: valid/ready plus status and date.
// Depends on iso_dp_pkg.
`timescale 1ns / 1ps

interface iso_dp_result_if import iso_dp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [YEAR_W-1:0]    year;
	logic [MONTH_W-1:0]   month;
	logic [DAY_W-1:0]     day;
	logic [DAY_NUM_W-1:0] day_number;

	modport source (output valid, output status, output year, output month,
		output day, output day_number, input ready);
	modport sink (input valid, input status, input year, input month,
		input day, input day_number, output ready);
endinterface

FILE: design/iso_dp_front.sv
// Front end: takes string bytes, accumulates decimal fields, tracks syntax
// and pushes one date record per terminator. Depends on iso_dp_pkg, macros.
`timescale 1ns / 1ps
`include "iso_date_parse_day_number_unit_macros.svh"

module iso_dp_front import iso_dp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	iso_dp_char_if.sink     chars,
	input  logic            q_full,
	output logic            q_push,
	output date_rec_t       q_rec
);

	field_t               fld_q, fld_d;
	logic [YEAR_BITS-1:0] acc_q, acc_d;
	logic                 sat_q, sat_d;
	logic                 seen_q, seen_d;
	logic                 mal_q, mal_d;
	logic [YEAR_BITS-1:0] hyear_q, hyear_d;
	logic                 hysat_q, hysat_d;
	logic [MONTH_W-1:0]   hmonth_q, hmonth_d;

	logic                 xfer;
	logic                 is_nul;
	logic                 is_digit;
	logic                 hyphen_ok;
	logic [YEAR_BITS+3:0] acc_x10;

	assign chars.ready = !q_full;
	assign xfer        = chars.valid && chars.ready;
	assign is_nul      = (chars.ch == CH_NUL);
	assign q_push      = xfer && is_nul;

	always_comb begin
		is_digit  = (chars.ch inside {[CH_ZERO:CH_NINE]});
		hyphen_ok = (chars.ch == CH_HYPHEN) && (fld_q != FLD_DAY) && seen_q;
		acc_x10   = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0}
			+ (YEAR_BITS+4)'(chars.ch[3:0]);

		q_rec.bad_syntax = mal_q || (fld_q != FLD_DAY) || !seen_q;
		q_rec.year_sat   = hysat_q;
		q_rec.year       = hyear_q;
		q_rec.month      = hmonth_q;
		q_rec.day_sat    = sat_q;
		q_rec.day        = acc_q;

		fld_d    = fld_q;
		acc_d    = acc_q;
		sat_d    = sat_q;
		seen_d   = seen_q;
		mal_d    = mal_q;
		hyear_d  = hyear_q;
		hysat_d  = hysat_q;
		hmonth_d = hmonth_q;

		if (xfer) begin
			if (is_nul) begin
				fld_d    = FLD_YEAR;
				acc_d    = '0;
				sat_d    = 1'b0;
				seen_d   = 1'b0;
				mal_d    = 1'b0;
				hyear_d  = '0;
				hysat_d  = 1'b0;
				hmonth_d = '0;
			end else if (!mal_q) begin
				if (is_digit) begin
					seen_d = 1'b1;
					if (sat_q || (|acc_x10[YEAR_BITS+3:YEAR_BITS])) begin
						acc_d = ACC_MAX;
						sat_d = 1'b1;
					end else begin
						acc_d = acc_x10[YEAR_BITS-1:0];
					end
				end else if (hyphen_ok) begin
					if (fld_q == FLD_YEAR) begin
						hyear_d = acc_q;
						hysat_d = sat_q;
						fld_d   = FLD_MONTH;
					end else begin
						hmonth_d = (!sat_q && acc_q >= YEAR_BITS'(1) && acc_q <= YEAR_BITS'(12))
							? acc_q[MONTH_W-1:0] : '0;
						fld_d    = FLD_DAY;
					end
					acc_d  = '0;
					sat_d  = 1'b0;
					seen_d = 1'b0;
				end else begin
					mal_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fld_q    <= FLD_YEAR;
			acc_q    <= '0;
			sat_q    <= 1'b0;
			seen_q   <= 1'b0;
			mal_q    <= 1'b0;
			hyear_q  <= '0;
			hysat_q  <= 1'b0;
			hmonth_q <= '0;
		end else begin
			fld_q    <= fld_d;
			acc_q    <= acc_d;
			sat_q    <= sat_d;
			seen_q   <= seen_d;
			mal_q    <= mal_d;
			hyear_q  <= hyear_d;
			hysat_q  <= hysat_d;
			hmonth_q <= hmonth_d;
		end
	end

	`ISO_DP_ASSERT_NXT(a_front_clear, clk, arst_n, q_push,
		fld_q == FLD_YEAR && !mal_q && !seen_q && !sat_q, "front not cleared after terminator")
	`ISO_DP_ASSERT_IMP(a_front_month, clk, arst_n, 1'b1,
		hmonth_q <= MONTH_DEC, "held month out of range")
	`ISO_DP_ASSERT_IMP(a_front_sat, clk, arst_n, sat_q,
		acc_q == ACC_MAX && seen_q, "saturated field without max value")

endmodule

FILE: design/iso_dp_queue.sv
// Small register queue of date records between front and back.
// Depends on iso_dp_pkg, macros.
`timescale 1ns / 1ps
`include "iso_date_parse_day_number_unit_macros.svh"

module iso_dp_queue import iso_dp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  date_rec_t wr_rec,
	output logic      full,
	input  logic      pop,
	output logic      rd_valid,
	output date_rec_t rd_rec
);

	date_rec_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_pop;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_rec   = mem_q[rd_ptr_q];
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push && !full, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ISO_DP_ASSERT_IMP(a_q_bound, clk, arst_n, 1'b1,
		count_q <= QCNT_W'(QDEPTH), "queue count past depth")
	`ISO_DP_ASSERT_IMP(a_q_no_overrun, clk, arst_n, push,
		!full, "transfer into full queue")
	`ISO_DP_ASSERT_IMP(a_q_ptr_gap, clk, arst_n, 1'b1,
		QPTR_W'(wr_ptr_q - rd_ptr_q) == count_q[QPTR_W-1:0], "pointer gap disagrees with count")

endmodule

FILE: design/iso_dp_back.sv
// Back end: checks a date record and computes the day number in three
// stages, the last one being the output register. Depends on iso_dp_pkg, macros.
`timescale 1ns / 1ps
`include "iso_date_parse_day_number_unit_macros.svh"

module iso_dp_back import iso_dp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  date_rec_t       q_rec,
	output logic            q_pop,
	iso_dp_result_if.source results
);

	logic                 en;

	logic                 v_s1;
	date_rec_t            rec_s1;
	logic [PROD_W-1:0]    p100_s1, p400_s1, y100_s1, y400_s1;

	logic                 v_s2;
	status_t              st_s2;
	date_rec_t            rec_s2;
	logic [DN_W-1:0]      y365_s2, lsum_s2, dpart_s2;

	logic                 v_s3;
	status_t              st_s3;
	logic [YEAR_W-1:0]    year_s3;
	logic [MONTH_W-1:0]   month_s3;
	logic [DAY_W-1:0]     day_s3;
	logic [DAY_NUM_W-1:0] dn_s3;

	logic [YEAR_BITS-1:0] p_yr;
	logic [Q_W-1:0]       q100p, q400p, q100y, q400y;
	logic                 leap;
	logic [4:0]           mlen;
	status_t              st_c;
	logic [DN_W-1:0]      dn_c;

	assign en    = !v_s3 || results.ready;
	assign q_pop = q_valid && en;
	assign p_yr  = q_rec.year - YEAR_BITS'(1);

	always_comb begin
		q100p = p100_s1[PROD_W-1:DIV_SHIFT];
		q400p = p400_s1[PROD_W-1:DIV_SHIFT];
		q100y = y100_s1[PROD_W-1:DIV_SHIFT];
		q400y = y400_s1[PROD_W-1:DIV_SHIFT];
		leap  = (rec_s1.year[1:0] == 2'b00) && ((q100y == q100p) || (q400y != q400p));
		mlen  = month_len(rec_s1.month, leap);
		if (rec_s1.bad_syntax) begin
			st_c = ST_MALFORMED;
		end else if (rec_s1.year_sat || rec_s1.year == '0) begin
			st_c = ST_YEAR_BAD;
		end else if (rec_s1.month == '0 || rec_s1.month > MONTH_DEC) begin
			st_c = ST_MONTH_BAD;
		end else if (rec_s1.day_sat || rec_s1.day == '0
			|| rec_s1.day > YEAR_BITS'(mlen)) begin
			st_c = ST_DAY_BAD;
		end else begin
			st_c = ST_OK;
		end
		dn_c = y365_s2 + lsum_s2 + dpart_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_s1  <= q_rec;
			p100_s1 <= PROD_W'(p_yr[YEAR_BITS-1:2]) * PROD_W'(DIV_MUL);
			p400_s1 <= PROD_W'(p_yr[YEAR_BITS-1:4]) * PROD_W'(DIV_MUL);
			y100_s1 <= PROD_W'(q_rec.year[YEAR_BITS-1:2]) * PROD_W'(DIV_MUL);
			y400_s1 <= PROD_W'(q_rec.year[YEAR_BITS-1:4]) * PROD_W'(DIV_MUL);

			st_s2     <= st_c;
			rec_s2    <= rec_s1;
			y365_s2   <= DN_W'(rec_s1.year) * DN_W'(365);
			lsum_s2   <= DN_W'((rec_s1.year - YEAR_BITS'(1)) >> 2)
				- DN_W'(q100p) + DN_W'(q400p);
			dpart_s2  <= DN_W'(days_before(rec_s1.month))
				+ DN_W'(leap && rec_s1.month > MONTH_FEB)
				+ DN_W'(rec_s1.day) - DN_W'(1);

			st_s3    <= st_s2;
			year_s3  <= (st_s2 == ST_OK) ? YEAR_W'(rec_s2.year) : '0;
			month_s3 <= (st_s2 == ST_OK) ? rec_s2.month : '0;
			day_s3   <= (st_s2 == ST_OK) ? DAY_W'(rec_s2.day) : '0;
			dn_s3    <= (st_s2 == ST_OK) ? DAY_NUM_W'(dn_c) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign results.valid      = v_s3;
	assign results.status     = st_s3;
	assign results.year       = year_s3;
	assign results.month      = month_s3;
	assign results.day        = day_s3;
	assign results.day_number = dn_s3;

	`ISO_DP_ASSERT_IMP(a_back_ok_fields, clk, arst_n, v_s3 && st_s3 == ST_OK,
		month_s3 != '0 && day_s3 != '0 && year_s3 != '0, "ok result with empty date")
	`ISO_DP_ASSERT_IMP(a_back_bad_zero, clk, arst_n, v_s3 && st_s3 != ST_OK,
		dn_s3 == '0 && year_s3 == '0 && month_s3 == '0, "failed result with date")
	`ISO_DP_ASSERT_NXT(a_back_hold, clk, arst_n, v_s3 && !results.ready,
		v_s3 && $stable(st_s3) && $stable(dn_s3), "result changed while stalled")

endmodule

FILE: design/iso_date_parse_day_number_unit.sv
// ISO date parser top level: front end, record queue and back end.
// Depends on iso_dp_pkg, the channel interfaces and the three submodules.
//
// Usage: the chars channel carries one byte per transfer of a string
// "year-month-day" ended by a zero byte. Bytes other than the zero byte
// produce nothing; each zero byte produces one transfer on the results
// channel with status, year, month, day and day_number (date fields are
// zero unless status is ok).
// Throughput: one byte per cycle while the record queue is not full, and one
// result per cycle while results.ready is high. Path: record queue, s1 product
// stage, s2 check and partial-sum stage, s3 output register with the day number.
// Reset (arst_n low) clears the parser state, the queue and the pipeline
// valid bits; the block is ready in the first cycle after release.
// When the receiver holds ready low the back end stalls in place; the
// four-entry record queue keeps taking bytes until it is full of pending
// strings, and only then is chars.ready dropped.
`timescale 1ns / 1ps

module iso_date_parse_day_number_unit import iso_dp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	iso_dp_char_if.sink     chars,
	iso_dp_result_if.source results
);

	logic      q_full;
	logic      q_push;
	date_rec_t q_wr_rec;
	logic      q_pop;
	logic      q_valid;
	date_rec_t q_rd_rec;

	iso_dp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.q_full (q_full),
		.q_push (q_push),
		.q_rec  (q_wr_rec)
	);

	iso_dp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_rec   (q_wr_rec),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_rec   (q_rd_rec)
	);

	iso_dp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_rec   (q_rd_rec),
		.q_pop   (q_pop),
		.results (results)
	);

endmodule

FILE: bench/tb.sv
// Self-checking bench for iso_date_parse_day_number_unit: streams date strings
// byte by byte and checks every result against a built-in parser and calendar.
// Depends on iso_dp_pkg, iso_dp_char_if, iso_dp_result_if and the RTL top level.
`timescale 1ns / 1ps

module tb;
	import iso_dp_pkg::*;

	localparam int ITEMS       = 1250;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int IDLE_PCT    = 27;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [YEAR_W-1:0]    year;
		logic [MONTH_W-1:0]   month;
		logic [DAY_W-1:0]     day;
		logic [DAY_NUM_W-1:0] day_number;
	} date_result_t;

	class date_scoreboard;
		date_result_t         dates_due[$];
		int                   errors;
		int                   checked;
		int                   bytes_seen;
		int                   tally[5];
		field_t               fld;
		logic [YEAR_BITS-1:0] acc;
		logic                 acc_sat;
		logic                 got_digit;
		logic                 bad_syntax;
		logic [YEAR_BITS-1:0] yr;
		logic                 yr_sat;
		logic [MONTH_W-1:0]   mon;

		function new();
			clear_string();
		endfunction

		static function bit leap_year(input int unsigned y);
			return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		endfunction

		static function int unsigned month_days(input int unsigned m, input bit leap);
			case (m)
				2:          return leap ? 29 : 28;
				4, 6, 9, 11: return 30;
				1, 3, 5, 7, 8, 10, 12: return 31;
				default:    return 0;
			endcase
		endfunction

		function void clear_field();
			acc = '0;
			acc_sat = 1'b0;
			got_digit = 1'b0;
		endfunction

		function void clear_string();
			fld = FLD_YEAR;
			clear_field();
			bad_syntax = 1'b0;
			yr = '0;
			yr_sat = 1'b0;
			mon = '0;
		endfunction

		function int pending();
			return dates_due.size();
		endfunction

		// one accepted byte; a zero byte closes the string and yields one date
		function void note_byte(input logic [CH_W-1:0] b);
			logic [31:0]  v;
			int unsigned  y;
			int unsigned  dn;
			int unsigned  len;
			bit           leap;
			date_result_t r;
			bytes_seen++;
			if (b != CH_NUL) begin
				if (bad_syntax)
					return;
				if (b >= CH_ZERO && b <= CH_NINE) begin
					v = acc * 10 + (b - CH_ZERO);
					if (acc_sat || v > ACC_MAX) begin
						acc = ACC_MAX;
						acc_sat = 1'b1;
					end else begin
						acc = v[YEAR_BITS-1:0];
					end
					got_digit = 1'b1;
				end else if (b == CH_HYPHEN && fld != FLD_DAY && got_digit) begin
					if (fld == FLD_YEAR) begin
						yr = acc;
						yr_sat = acc_sat;
						fld = FLD_MONTH;
					end else begin
						mon = (!acc_sat && acc >= 1 && acc <= 12) ? acc[MONTH_W-1:0] : '0;
						fld = FLD_DAY;
					end
					clear_field();
				end else begin
					bad_syntax = 1'b1;
				end
				return;
			end
			r = '0;
			y = yr;
			leap = leap_year(y);
			len = month_days(mon, leap);
			if (bad_syntax || fld != FLD_DAY || !got_digit) begin
				r.status = ST_MALFORMED;
			end else if (yr_sat || y == 0) begin
				r.status = ST_YEAR_BAD;
			end else if (mon == 0) begin
				r.status = ST_MONTH_BAD;
			end else if (acc_sat || acc == 0 || acc > len) begin
				r.status = ST_DAY_BAD;
			end else begin
				dn = 365 * y + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + acc - 1;
				for (int k = 1; k < mon; k++)
					dn += month_days(k, leap);
				r.status = ST_OK;
				r.year = yr;
				r.month = mon;
				r.day = acc[DAY_W-1:0];
				r.day_number = dn[DAY_NUM_W-1:0];
			end
			dates_due.push_back(r);
			clear_string();
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 40)
				$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		task check_result(input date_result_t got);
			date_result_t want;
			if (dates_due.size() == 0) begin
				report($sformatf("result with none due, status %0d", got.status));
				return;
			end
			want = dates_due.pop_front();
			checked++;
			tally[want.status]++;
			if (got.status !== want.status)
				report($sformatf("date %0d: status %0d, want %0d", checked, got.status,
					want.status));
			if (got.year !== want.year)
				report($sformatf("date %0d: year %0d, want %0d", checked, got.year, want.year));
			if (got.month !== want.month)
				report($sformatf("date %0d: month %0d, want %0d", checked, got.month,
					want.month));
			if (got.day !== want.day)
				report($sformatf("date %0d: day %0d, want %0d", checked, got.day, want.day));
			if (got.day_number !== want.day_number)
				report($sformatf("date %0d: day_number %0d, want %0d", checked,
					got.day_number, want.day_number));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   gaps_on;
	bit   hold_req;
	int   hold_left;
	int   stall_cycles;

	date_scoreboard sb;

	iso_dp_char_if   char_ch ();
	iso_dp_result_if res_ch ();

	iso_date_parse_day_number_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (char_ch),
		.results (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && char_ch.valid && char_ch.ready)
			sb.note_byte(char_ch.ch);
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result('{res_ch.status, res_ch.year, res_ch.month, res_ch.day,
				res_ch.day_number});
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles + 1 >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
				$display("FAIL iso_date_parse_day_number_unit");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// result sink: random back-pressure plus an on-demand long hold
	initial begin
		res_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	task automatic send_byte(input logic [CH_W-1:0] b);
		if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			char_ch.valid <= 1'b0;
			char_ch.ch <= CH_W'($urandom);
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		char_ch.valid <= 1'b1;
		char_ch.ch <= b;
		@(posedge clk);
		while (!char_ch.ready) @(posedge clk);
	endtask

	task automatic send_string(input logic [CH_W-1:0] s[$]);
		foreach (s[i])
			send_byte(s[i]);
		send_byte(CH_NUL);
	endtask

	task automatic send_text(input string t);
		logic [CH_W-1:0] s[$];
		for (int i = 0; i < t.len(); i++)
			s.push_back(t[i]);
		send_string(s);
	endtask

	task automatic drain();
		@(negedge clk);
		char_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic put_num(ref logic [CH_W-1:0] s[$], input int unsigned v);
		string t;
		t = $sformatf("%0d", v);
		if ($urandom_range(7) == 0)
			repeat ($urandom_range(1, 3)) s.push_back(CH_ZERO);
		for (int i = 0; i < t.len(); i++)
			s.push_back(t[i]);
	endtask

	task automatic build_date(ref logic [CH_W-1:0] s[$]);
		int unsigned y;
		int unsigned m;
		int unsigned d;
		int unsigned len;
		case ($urandom_range(19))
			0:       y = 0;
			1:       y = $urandom_range(65536, 999999);
			2:       y = $urandom_range(65530, 65535);
			3, 4, 5: y = $urandom_range(1, 65535);
			default: y = $urandom_range(1, 9999);
		endcase
		case ($urandom_range(19))
			0:       m = 0;
			1:       m = $urandom_range(13, 99);
			2:       m = $urandom_range(65530, 99999);
			default: m = $urandom_range(1, 12);
		endcase
		len = date_scoreboard::month_days(m, date_scoreboard::leap_year(y));
		if (len == 0)
			len = 31;
		case ($urandom_range(19))
			0:       d = 0;
			1:       d = len + 1;
			2:       d = $urandom_range(32, 99999);
			3:       d = len;
			4:       d = $urandom_range(65530, 65540);
			default: d = $urandom_range(1, len);
		endcase
		s.delete();
		put_num(s, y);
		s.push_back(CH_HYPHEN);
		put_num(s, m);
		s.push_back(CH_HYPHEN);
		put_num(s, d);
	endtask

	initial begin
		logic [CH_W-1:0] s[$];
		string           dates[$];
		int              items;
		bit              held;
		bit              paused;
		sb = new();
		arst_n = 1'b0;
		char_ch.valid = 1'b0;
		char_ch.ch = '0;
		gaps_on = 1'b1;
		hold_req = 1'b0;
		stall_cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		dates = '{"", "1-1-1", "65535-12-31", "2000-02-29", "1900-02-29", "2024-03-01",
			"0-1-1", "65536-1-1", "2023-13-01", "2023-0-01", "2023-70000-1", "2023-04-31",
			"2023-01-0", "2023-01-70000", "0002023-001-0001", "-1-1", "2023-01",
			"2023-01-", "2023-01-01-", "20x3-01-01", "2023--01"};
		foreach (dates[i])
			send_text(dates[i]);
		s = '{8'hFF, 8'h80};
		send_string(s);

		items = 0;
		held = 1'b0;
		paused = 1'b0;
		while (items < ITEMS) begin
			if (!held && items >= 400) begin
				held = 1'b1;
				hold_req = 1'b1;
			end
			if (!paused && items >= 600) begin
				paused = 1'b1;
				drain();
			end
			gaps_on = !(items >= 700 && items < 950);
			case ($urandom_range(9))
				0: begin
					s.delete();
					repeat ($urandom_range(1, 6)) s.push_back(CH_W'($urandom_range(1, 255)));
					items += 1;
				end
				1: begin
					build_date(s);
					case ($urandom_range(3))
						0: s.insert($urandom_range(s.size()), CH_W'($urandom_range(1, 255)));
						1: s.delete($urandom_range(s.size() - 1));
						2: repeat ($urandom_range(1, s.size() - 1)) void'(s.pop_back());
						default: begin
							s.push_back(CH_HYPHEN);
							put_num(s, $urandom_range(99));
						end
					endcase
					items += s.size() + 1;
				end
				default: begin
					build_date(s);
					items += s.size() + 1;
				end
			endcase
			send_string(s);
		end

		gaps_on = 1'b1;
		drain();
		repeat (8) @(posedge clk);
		$display("%0d bytes, %0d dates: ok %0d, malformed %0d, bad year %0d, bad month %0d, %s",
			sb.bytes_seen, sb.checked, sb.tally[0], sb.tally[1], sb.tally[2], sb.tally[3],
			$sformatf("bad day %0d", sb.tally[4]));
		$display("Included a %0d-cycle result hold-off, a drain pause and a no-idle stretch",
			HOLD_CYCLES);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS iso_date_parse_day_number_unit");
		else
			$display("FAIL iso_date_parse_day_number_unit");
		$finish;
	end

endmodule
